[src/sprite_quad_camera_transform_assert.svh]
// Assertion macros for the sprite quad camera transform checker.
// Both macros expect clk and rst to be visible in the using scope.
`ifndef SPRITE_QUAD_CAMERA_TRANSFORM_ASSERT_SVH
`define SPRITE_QUAD_CAMERA_TRANSFORM_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SQCT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define SQCT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[src/sqct_pkg.sv]
// Shared constants for the sprite quad camera transform.
// Holds the CORDIC table and gain, quadrant codes and register indexes; no dependencies.
`timescale 1ns / 1ps
package sqct_pkg;

  localparam int ATAN_LEN = 24;

  // atan(2^-i) in units of 2^32 per turn
  localparam logic [31:0] ATAN_TAB [ATAN_LEN] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
  };

  // CORDIC gain, Q2.30
  localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032874;

  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  localparam logic [2:0] REG_CAMERA_X     = 3'd0;
  localparam logic [2:0] REG_CAMERA_Y     = 3'd1;
  localparam logic [2:0] REG_CAMERA_ZOOM  = 3'd2;
  localparam logic [2:0] REG_CAMERA_ANGLE = 3'd3;
  localparam logic [2:0] REG_FRAME_WIDTH  = 3'd4;
  localparam logic [2:0] REG_FRAME_HEIGHT = 3'd5;

endpackage

[src/sqct_cordic.sv]
// Pipelined rotation-mode CORDIC giving Q2.30 cosine and sine of a binary angle.
// Depends on sqct_pkg; the load, every step and the quadrant fold are registered.
`timescale 1ns / 1ps
module sqct_cordic
  import sqct_pkg::*;
#(
  parameter int STEPS = 16
) (
  input  logic                clk,
  input  logic                en,
  input  logic [15:0]         angle,
  output logic signed [32:0]  cos_q,
  output logic signed [32:0]  sin_q
);

  logic signed [32:0] x [STEPS+1];
  logic signed [32:0] y [STEPS+1];
  logic signed [32:0] z [STEPS+1];
  logic [1:0]         q [STEPS+1];

  // load start vector, quadrant held aside
  always_ff @(posedge clk) begin
    if (en) begin
      x[0] <= CORDIC_GAIN;
      y[0] <= '0;
      z[0] <= signed'({3'b000, angle[13:0], 16'h0000});
      q[0] <= angle[15:14];
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    logic signed [32:0] at;
    assign at = signed'({1'b0, ATAN_TAB[i]});
    always_ff @(posedge clk) begin
      if (en) begin
        q[i+1] <= q[i];
        if (z[i] >= 0) begin
          x[i+1] <= x[i] - (y[i] >>> i);
          y[i+1] <= y[i] + (x[i] >>> i);
          z[i+1] <= z[i] - at;
        end else begin
          x[i+1] <= x[i] + (y[i] >>> i);
          y[i+1] <= y[i] - (x[i] >>> i);
          z[i+1] <= z[i] + at;
        end
      end
    end
  end

  // fold the quadrant back in
  always_ff @(posedge clk) begin
    if (en) begin
      case (q[STEPS])
        QUAD_0: begin cos_q <= x[STEPS];  sin_q <= y[STEPS];  end
        QUAD_1: begin cos_q <= -y[STEPS]; sin_q <= x[STEPS];  end
        QUAD_2: begin cos_q <= -x[STEPS]; sin_q <= -y[STEPS]; end
        default: begin cos_q <= y[STEPS]; sin_q <= -x[STEPS]; end
      endcase
    end
  end

endmodule

[src/sprite_quad_camera_transform.sv]
// Sprite quad camera transform, top level.
// Depends on sqct_pkg and sqct_cordic.
`timescale 1ns / 1ps
// One sprite request enters per clock while the output is not stalled, and one
// result (four screen corners and the tint) leaves for each. A request passes
// through the CORDIC pipeline (one register per iteration plus load and quadrant
// fold), alongside the input register and delay line, then eight arithmetic
// stages: offset products, offset rounding, camera subtract, zoom product,
// zoom round and saturate, camera rotation products, rotation rounding, and
// centre add with 24-bit saturation. A stalled output freezes the whole
// pipeline, so s_tready follows m_tready whenever a result is waiting.
// Camera registers are taken on the cfg channel, which is always ready; write
// them only while no sprite is in flight. The camera sine and cosine come from
// a second free-running CORDIC and settle once a write of camera_angle has
// passed its load, steps and quadrant fold.
module sprite_quad_camera_transform
  import sqct_pkg::*;
#(
  parameter int CORDIC_STEPS = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // pos_x[23:0], pos_y[47:24], tex_width[58:48], tex_height[69:59],
  // sprite_angle[85:70], scale_x[101:86], scale_y[117:102], tint[149:118], zero pad
  input  logic [151:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // corner0_x[23:0], corner0_y[47:24], corner1_x[71:48], corner1_y[95:72],
  // corner2_x[119:96], corner2_y[143:120], corner3_x[167:144],
  // corner3_y[191:168], tint_out[223:192]
  output logic [223:0] m_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [23:0]  cfg_data
);

  localparam int LAT = CORDIC_STEPS + 2;

  typedef struct packed {
    logic signed [23:0] px;
    logic signed [23:0] py;
    logic signed [27:0] w;
    logic signed [27:0] h;
    logic [31:0]        tint;
  } item_t;

  typedef struct packed {
    logic signed [23:0] px;
    logic signed [23:0] py;
    logic [31:0]        tint;
  } side_t;

  // ---------------- configuration registers ----------------
  logic signed [23:0] camera_x;
  logic signed [23:0] camera_y;
  logic signed [15:0] camera_zoom;
  logic [15:0]        camera_angle;
  logic [9:0]         frame_width;
  logic [9:0]         frame_height;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      camera_x     <= '0;
      camera_y     <= '0;
      camera_zoom  <= 16'sd256;
      camera_angle <= 16'd16384;
      frame_width  <= 10'd640;
      frame_height <= 10'd480;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_CAMERA_X:     camera_x     <= signed'(cfg_data);
        REG_CAMERA_Y:     camera_y     <= signed'(cfg_data);
        REG_CAMERA_ZOOM:  camera_zoom  <= signed'(cfg_data[15:0]);
        REG_CAMERA_ANGLE: camera_angle <= cfg_data[15:0];
        REG_FRAME_WIDTH:  frame_width  <= cfg_data[9:0];
        REG_FRAME_HEIGHT: frame_height <= cfg_data[9:0];
        default: ;  // drop writes to unused indexes
      endcase
    end
  end

  // screen centre in Q.8: half the frame size
  logic signed [17:0] cx;
  logic signed [17:0] cy;
  assign cx = signed'({1'b0, frame_width, 7'b0});
  assign cy = signed'({1'b0, frame_height, 7'b0});

  // ---------------- pipeline control ----------------
  // advance everything unless a finished result is held
  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  logic accept;
  assign accept = s_tvalid && s_tready;

  // ---------------- input stage ----------------
  logic               a_valid;
  logic signed [23:0] a_px;
  logic signed [23:0] a_py;
  logic [10:0]        a_tw;
  logic [10:0]        a_th;
  logic signed [15:0] a_sx;
  logic signed [15:0] a_sy;
  logic [31:0]        a_tint;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en) begin
      a_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_px   <= signed'(s_tdata[23:0]);
      a_py   <= signed'(s_tdata[47:24]);
      a_tw   <= s_tdata[58:48];
      a_th   <= s_tdata[69:59];
      a_sx   <= signed'(s_tdata[101:86]);
      a_sy   <= signed'(s_tdata[117:102]);
      a_tint <= s_tdata[149:118];
    end
  end

  // ---------------- sine and cosine ----------------
  logic signed [32:0] sc;
  logic signed [32:0] ss;
  logic signed [32:0] cc;
  logic signed [32:0] cs;

  sqct_cordic #(.STEPS(CORDIC_STEPS)) u_sprite_cordic (
    .clk   (clk),
    .en    (en),
    .angle (s_tdata[85:70]),
    .cos_q (sc),
    .sin_q (ss)
  );

  // the user keeps camera angle static while sprites are in flight (the block does not enforce it): let it run freely
  sqct_cordic #(.STEPS(CORDIC_STEPS)) u_camera_cordic (
    .clk   (clk),
    .en    (1'b1),
    .angle (camera_angle),
    .cos_q (cc),
    .sin_q (cs)
  );

  // ---------------- delay line alongside the CORDIC ----------------
  item_t              dl   [LAT-1];
  logic [LAT-2:0]     dl_v;
  logic signed [27:0] w_a;
  logic signed [27:0] h_a;

  assign w_a = signed'({1'b0, a_tw}) * a_sx;
  assign h_a = signed'({1'b0, a_th}) * a_sy;

  always_ff @(posedge clk) begin
    if (rst) begin
      dl_v <= '0;
    end else if (en) begin
      dl_v <= {dl_v[LAT-3:0], a_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dl[0] <= '{px: a_px, py: a_py, w: w_a, h: h_a, tint: a_tint};
      for (int k = 1; k < LAT - 1; k++) begin
        dl[k] <= dl[k-1];
      end
    end
  end

  item_t d_end;
  assign d_end = dl[LAT-2];

  // ---------------- arithmetic stages ----------------
  logic [8:1] pv;
  side_t      sd [8:1];

  always_ff @(posedge clk) begin
    if (rst) begin
      pv <= '0;
    end else if (en) begin
      pv <= {pv[7:1], dl_v[LAT-2]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd[1] <= '{px: d_end.px, py: d_end.py, tint: d_end.tint};
      for (int k = 2; k <= 8; k++) begin
        sd[k] <= sd[k-1];
      end
    end
  end

  // stage 1: offset products, Q.8 times Q2.30
  logic signed [60:0] p_wc, p_ws, p_hc, p_hs;

  always_ff @(posedge clk) begin
    if (en) begin
      p_wc <= d_end.w * sc;
      p_ws <= d_end.w * ss;
      p_hc <= d_end.h * sc;
      p_hs <= d_end.h * ss;
    end
  end

  // stage 2: corner offsets rotated about the top-left, rounded to Q.8
  logic signed [61:0] ox_sum [4];
  logic signed [61:0] oy_sum [4];
  logic signed [31:0] off_x  [4];
  logic signed [31:0] off_y  [4];

  always_comb begin
    ox_sum[0] = '0;
    oy_sum[0] = '0;
    ox_sum[1] = 62'(p_wc);
    oy_sum[1] = 62'(p_ws);
    ox_sum[2] = 62'(p_wc) - 62'(p_hs);
    oy_sum[2] = 62'(p_ws) + 62'(p_hc);
    ox_sum[3] = -62'(p_hs);
    oy_sum[3] = 62'(p_hc);
  end

  // stage 3..8 per corner
  logic signed [31:0] vx  [4];
  logic signed [31:0] vy  [4];
  logic signed [47:0] zx  [4];
  logic signed [47:0] zy  [4];
  logic signed [31:0] zcx [4];
  logic signed [31:0] zcy [4];
  logic signed [64:0] m_a [4];
  logic signed [64:0] m_b [4];
  logic signed [64:0] m_c [4];
  logic signed [64:0] m_d [4];
  logic signed [35:0] rx  [4];
  logic signed [35:0] ry  [4];
  logic signed [23:0] ox  [4];
  logic signed [23:0] oy  [4];

  function automatic logic signed [31:0] sat32(input logic signed [40:0] v);
    logic signed [40:0] hi;
    logic signed [40:0] lo;
    hi = 41'sd2147483647;
    lo = -41'sd2147483648;
    if (v > hi) return 32'sh7FFFFFFF;
    if (v < lo) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [36:0] v);
    logic signed [36:0] hi;
    logic signed [36:0] lo;
    hi = 37'sd8388607;
    lo = -37'sd8388608;
    if (v > hi) return 24'sh7FFFFF;
    if (v < lo) return 24'sh800000;
    return v[23:0];
  endfunction

  for (genvar k = 0; k < 4; k++) begin : g_corner
    logic signed [61:0] rxs;
    logic signed [61:0] rys;
    logic signed [48:0] zxr;
    logic signed [48:0] zyr;
    logic signed [65:0] rxr;
    logic signed [65:0] ryr;

    assign rxs = ox_sum[k] + (62'sd1 <<< 29);
    assign rys = oy_sum[k] + (62'sd1 <<< 29);
    assign zxr = 49'(zx[k]) + 49'sd128;
    assign zyr = 49'(zy[k]) + 49'sd128;
    assign rxr = 66'(m_a[k]) - 66'(m_b[k]) + (66'sd1 <<< 29);
    assign ryr = 66'(m_c[k]) + 66'(m_d[k]) + (66'sd1 <<< 29);

    always_ff @(posedge clk) begin
      if (en) begin
        // round the rotated offset
        off_x[k] <= 32'(rxs >>> 30);
        off_y[k] <= 32'(rys >>> 30);
        // world to view: place, drop camera and screen centre
        vx[k] <= 32'(sd[2].px) + off_x[k] - 32'(camera_x) - 32'(cx);
        vy[k] <= 32'(sd[2].py) + off_y[k] - 32'(camera_y) - 32'(cy);
        // zoom
        zx[k] <= vx[k] * camera_zoom;
        zy[k] <= vy[k] * camera_zoom;
        zcx[k] <= sat32(41'(zxr >>> 8));
        zcy[k] <= sat32(41'(zyr >>> 8));
        // camera rotation
        m_a[k] <= zcx[k] * cc;
        m_b[k] <= zcy[k] * cs;
        m_c[k] <= zcx[k] * cs;
        m_d[k] <= zcy[k] * cc;
        rx[k] <= 36'(rxr >>> 30);
        ry[k] <= 36'(ryr >>> 30);
        // back to screen, clip to Q16.8
        ox[k] <= sat24(37'(rx[k]) + 37'(cx));
        oy[k] <= sat24(37'(ry[k]) + 37'(cy));
      end
    end

    assign m_tdata[48*k +: 24]      = ox[k];
    assign m_tdata[48*k + 24 +: 24] = oy[k];
  end

  assign m_tdata[223:192] = sd[8].tint;
  assign m_tvalid         = pv[8];

endmodule

[src/sqct_checker.sv]
// Port-level checker for the sprite quad camera transform, with its bind.
// Depends on sprite_quad_camera_transform_assert.svh.
`timescale 1ns / 1ps
`include "sprite_quad_camera_transform_assert.svh"
module sqct_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [223:0] m_tdata
);

  // a held result stays put
  `SQCT_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")
  // a held result blocks new requests
  `SQCT_ASSERT_NOW(a_stall_blocks_in, m_tvalid && !m_tready, !s_tready, "request taken while output stalled")
  // an empty output never blocks the input
  `SQCT_ASSERT_NOW(a_ready_when_free, !m_tvalid || m_tready, s_tready, "input blocked with free output")
  // nothing comes out right after reset
  `SQCT_ASSERT_NOW(a_empty_after_rst, $past(rst), !m_tvalid, "result right after reset")

endmodule

bind sprite_quad_camera_transform sqct_checker u_sqct_checker (.*);

[test/sprite_quad_camera_transform_tb.sv]
// Self-checking bench for sprite_quad_camera_transform: sprites in, four screen corners out.
// Depends on sqct_pkg and the block itself; carries its own fixed-point corner predictor.
`timescale 1ns / 1ps
module sprite_quad_camera_transform_tb;
  import sqct_pkg::*;

  localparam int STEPS       = 16;
  localparam int LATENCY     = STEPS + 10;
  localparam int ANGLE_SETTLE = STEPS + 2;
  localparam int STALL_LIMIT = 4000;

  typedef struct packed {
    logic [31:0]        tint;
    logic signed [15:0] scale_y;
    logic signed [15:0] scale_x;
    logic [15:0]        sprite_angle;
    logic [10:0]        tex_height;
    logic [10:0]        tex_width;
    logic signed [23:0] pos_y;
    logic signed [23:0] pos_x;
  } sprite_t;

  typedef struct packed {
    logic [2:0]  index;
    logic [23:0] data;
  } reg_write_t;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [151:0] s_tdata;
  logic         m_tvalid;
  logic         m_tready;
  logic [223:0] m_tdata;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [2:0]   cfg_index;
  logic [23:0]  cfg_data;

  sprite_quad_camera_transform #(.CORDIC_STEPS(STEPS)) u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Camera copy kept by the predictor, updated on each register handshake.
  logic signed [23:0] cam_x;
  logic signed [23:0] cam_y;
  logic signed [15:0] cam_zoom;
  logic [15:0]        cam_angle;
  logic [9:0]         fb_width;
  logic [9:0]         fb_height;

  sprite_t      sprite_q[$];
  reg_write_t   reg_q[$];
  logic [223:0] corners_q[$];
  sprite_t      cur_sprite;

  bit calm;          // no idling on either side
  int sprites_sent = 0;
  int quads_seen = 0;
  int reg_writes = 0;
  int mismatches = 0;
  int quiet_cycles;
  int src_gap;
  int sink_stall;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Rotation-mode CORDIC: sine and cosine in Q2.30 for a 16-bit binary angle.
  function automatic void cordic_sincos(input logic [15:0] ang,
                                        output longint cos_v, output longint sin_v);
    longint x;
    longint y;
    longint z;
    longint dx;
    longint dy;
    x = 652032874;
    y = 0;
    z = longint'(ang[13:0]) << 16;
    for (int i = 0; i < STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx; y = y + dy; z = z - longint'(ATAN_TAB[i]);
      end else begin
        x = x + dx; y = y - dy; z = z + longint'(ATAN_TAB[i]);
      end
    end
    case (ang[15:14])
      QUAD_0: begin cos_v = x;  sin_v = y;  end
      QUAD_1: begin cos_v = -y; sin_v = x;  end
      QUAD_2: begin cos_v = -x; sin_v = -y; end
      default: begin cos_v = y; sin_v = -x; end
    endcase
  endfunction

  // Round half up, then drop s fraction bits.
  function automatic longint round_q(input longint v, input int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clip(input longint v, input longint lo, input longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Screen corners and tint for one sprite under the current camera.
  function automatic logic [223:0] sprite_corners(input sprite_t sp);
    logic [223:0] r;
    longint w, h, sc, ss, cc, cs, cx, cy;
    longint ox, oy, wx, wy, vx, vy, rx, ry;
    w = longint'(sp.tex_width) * longint'(sp.scale_x);
    h = longint'(sp.tex_height) * longint'(sp.scale_y);
    cx = longint'(fb_width) << 7;
    cy = longint'(fb_height) << 7;
    cordic_sincos(sp.sprite_angle, sc, ss);
    cordic_sincos(cam_angle, cc, cs);
    for (int k = 0; k < 4; k++) begin
      ox = (k == 1 || k == 2) ? w : 0;
      oy = (k >= 2) ? h : 0;
      wx = longint'(sp.pos_x) + round_q(ox * sc - oy * ss, 30);
      wy = longint'(sp.pos_y) + round_q(ox * ss + oy * sc, 30);
      vx = wx - longint'(cam_x) - cx;
      vy = wy - longint'(cam_y) - cy;
      vx = clip(round_q(vx * longint'(cam_zoom), 8), -(longint'(1) << 31), (longint'(1) << 31) - 1);
      vy = clip(round_q(vy * longint'(cam_zoom), 8), -(longint'(1) << 31), (longint'(1) << 31) - 1);
      rx = clip(round_q(vx * cc - vy * cs, 30) + cx, -8388608, 8388607);
      ry = clip(round_q(vx * cs + vy * cc, 30) + cy, -8388608, 8388607);
      r[48*k +: 24]      = rx[23:0];
      r[48*k + 24 +: 24] = ry[23:0];
    end
    r[223:192] = sp.tint;
    return r;
  endfunction

  // Sprite source: hold each request until taken, insert random gaps.
  always @(posedge clk) begin : sprite_source
    logic next_valid;
    if (rst) begin
      s_tvalid   <= 1'b0;
      s_tdata    <= '0;
      src_gap    <= 0;
      cur_sprite = '0;
    end else begin
      next_valid = s_tvalid;
      if (s_tvalid && s_tready) begin
        corners_q.push_back(sprite_corners(cur_sprite));
        sprites_sent++;
        next_valid = 1'b0;
      end
      if (!next_valid) begin
        if (src_gap > 0 && !calm) begin
          src_gap <= src_gap - 1;
        end else if (sprite_q.size() > 0) begin
          cur_sprite = sprite_q.pop_front();
          next_valid = 1'b1;
          if (!calm && $urandom_range(0, 9) == 0) src_gap <= $urandom_range(1, 16);
        end
      end
      s_tvalid <= next_valid;
      s_tdata  <= {2'b00, cur_sprite};
    end
  end

  // Register writer: one pending write at a time, mirrored into the camera copy.
  always @(posedge clk) begin : reg_writer
    reg_write_t wr;
    logic next_valid;
    if (rst) begin
      cfg_valid <= 1'b0;
      cfg_index <= '0;
      cfg_data  <= '0;
      cam_x     <= '0;
      cam_y     <= '0;
      cam_zoom  <= 16'sd256;
      cam_angle <= 16'd16384;
      fb_width  <= 10'd640;
      fb_height <= 10'd480;
    end else begin
      next_valid = cfg_valid;
      if (cfg_valid && cfg_ready) begin
        reg_writes++;
        next_valid = 1'b0;
        case (cfg_index)
          REG_CAMERA_X:     cam_x     <= cfg_data;
          REG_CAMERA_Y:     cam_y     <= cfg_data;
          REG_CAMERA_ZOOM:  cam_zoom  <= cfg_data[15:0];
          REG_CAMERA_ANGLE: cam_angle <= cfg_data[15:0];
          REG_FRAME_WIDTH:  fb_width  <= cfg_data[9:0];
          REG_FRAME_HEIGHT: fb_height <= cfg_data[9:0];
          default: ;
        endcase
      end
      if (!next_valid && reg_q.size() > 0) begin
        wr = reg_q.pop_front();
        next_valid = 1'b1;
        cfg_index <= wr.index;
        cfg_data  <= wr.data;
      end
      cfg_valid <= next_valid;
    end
  end

  // Result sink: random backpressure, field-by-field check, stall watchdog.
  always @(posedge clk) begin : quad_sink
    logic [223:0] want;
    int lo;
    int wd;
    bit bad;
    if (rst) begin
      m_tready     <= 1'b0;
      sink_stall   <= 0;
      quiet_cycles <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        quads_seen++;
        if (corners_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", m_tdata);
        end else begin
          want = corners_q.pop_front();
          bad = 1'b0;
          for (int f = 0; f < 9; f++) begin
            lo = 24 * f;
            wd = (f == 8) ? 32 : 24;
            if (((want >> lo) & ((224'd1 << wd) - 1)) !== ((m_tdata >> lo) & ((224'd1 << wd) - 1))) begin
              bad = 1'b1;
              if (mismatches < 10)
                $display("result %0d field %0d: expected %h got %h", quads_seen, f,
                         (want >> lo) & ((224'd1 << wd) - 1),
                         (m_tdata >> lo) & ((224'd1 << wd) - 1));
            end
          end
          if (bad) mismatches++;
        end
      end
      // Watchdog: any handshake resets the count.
      if ((m_tvalid && m_tready) || (s_tvalid && s_tready) || (cfg_valid && cfg_ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
        $display("sprite_quad_camera_transform test failed");
        $finish;
      end
      if (sink_stall > 0 && !calm) begin
        sink_stall <= sink_stall - 1;
        m_tready   <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        if (!calm && $urandom_range(0, 11) == 0) sink_stall <= $urandom_range(1, 16);
      end
    end
  end

  function automatic sprite_t make_sprite(input logic [23:0] px, input logic [23:0] py,
                                          input int tw, input int th, input logic [15:0] ang,
                                          input logic [15:0] sx, input logic [15:0] sy,
                                          input logic [31:0] tint);
    sprite_t sp;
    sp.pos_x = px; sp.pos_y = py;
    sp.tex_width = tw[10:0]; sp.tex_height = th[10:0];
    sp.sprite_angle = ang; sp.scale_x = sx; sp.scale_y = sy; sp.tint = tint;
    return sp;
  endfunction

  // Mostly plausible sprites, some with position, scale and tint drawn from their full range.
  function automatic sprite_t random_sprite();
    sprite_t sp;
    if ($urandom_range(0, 3) == 0) begin
      sp = make_sprite(24'($urandom), 24'($urandom), $urandom_range(0, 1024),
                       $urandom_range(0, 1024), 16'($urandom), 16'($urandom),
                       16'($urandom), $urandom);
    end else begin
      sp = make_sprite(24'($urandom_range(0, 2 ** 19) - 2 ** 18),
                       24'($urandom_range(0, 2 ** 19) - 2 ** 18),
                       $urandom_range(0, 256), $urandom_range(0, 256), 16'($urandom),
                       16'($urandom_range(0, 1024) - 256), 16'($urandom_range(0, 1024) - 256),
                       $urandom);
    end
    return sp;
  endfunction

  task automatic write_reg(input logic [2:0] idx, input logic [23:0] val);
    reg_write_t wr;
    wr.index = idx;
    wr.data  = val;
    reg_q.push_back(wr);
  endtask

  // Drain the pipe, then let the last requests clear before touching registers.
  task automatic wait_idle();
    @(negedge clk);
    while (sprite_q.size() > 0 || s_tvalid || corners_q.size() > 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  // Apply queued writes and give the camera sine/cosine time to settle.
  task automatic commit_regs();
    @(negedge clk);
    while (reg_q.size() > 0 || cfg_valid) @(negedge clk);
    repeat (ANGLE_SETTLE + 4) @(negedge clk);
  endtask

  task automatic random_camera(input bit extreme);
    if (extreme) begin
      write_reg(REG_CAMERA_X, $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000);
      write_reg(REG_CAMERA_Y, $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000);
      write_reg(REG_CAMERA_ZOOM, $urandom_range(0, 1) ? 24'h007FFF : 24'h008000);
      write_reg(REG_CAMERA_ANGLE, $urandom_range(0, 1) ? 24'h00FFFF : 24'h000000);
      write_reg(REG_FRAME_WIDTH, $urandom_range(0, 1) ? 24'd1023 : 24'd0);
      write_reg(REG_FRAME_HEIGHT, $urandom_range(0, 1) ? 24'd1023 : 24'd0);
    end else begin
      write_reg(REG_CAMERA_X, 24'($urandom));
      write_reg(REG_CAMERA_Y, 24'($urandom_range(0, 2 ** 18)));
      write_reg(REG_CAMERA_ZOOM,
                24'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(64, 1024)));
      write_reg(REG_CAMERA_ANGLE, 24'($urandom));
      write_reg(REG_FRAME_WIDTH, 24'($urandom));
      write_reg(REG_FRAME_HEIGHT, 24'($urandom));
    end
  endtask

  initial begin : stimulus
    calm = 1'b0;
    rst = 1'b1;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    repeat (ANGLE_SETTLE + 4) @(negedge clk);

    // Directed sprites under the reset camera: field extremes, quadrant
    // boundaries of the angle, zero and negative sizes, full tint range.
    sprite_q.push_back(make_sprite(0, 0, 0, 0, 16'd0, 16'sd256, 16'sd256, 32'h0));
    sprite_q.push_back(make_sprite(24'h7FFFFF, 24'h7FFFFF, 1024, 1024, 16'd0,
                                   16'h7FFF, 16'h7FFF, 32'hFFFFFFFF));
    sprite_q.push_back(make_sprite(24'h800000, 24'h800000, 1024, 1024, 16'hFFFF,
                                   16'h8000, 16'h8000, 32'hA5A5A5A5));
    sprite_q.push_back(make_sprite(24'h800000, 24'h7FFFFF, 1024, 0, 16'd16384,
                                   16'h7FFF, 16'h8000, 32'h5A5A5A5A));
    sprite_q.push_back(make_sprite(24'h001000, 24'h002000, 64, 32, 16'd16384,
                                   16'sd256, 16'sd256, 32'h12345678));
    sprite_q.push_back(make_sprite(24'h001000, 24'h002000, 64, 32, 16'd32768,
                                   16'sd256, 16'sd256, 32'h9ABCDEF0));
    sprite_q.push_back(make_sprite(24'h001000, 24'h002000, 64, 32, 16'd49152,
                                   16'sd256, 16'sd256, 32'h0F0F0F0F));
    sprite_q.push_back(make_sprite(24'h001000, 24'h002000, 64, 32, 16'd8192,
                                   -16'sd256, 16'sd512, 32'hF0F0F0F0));
    sprite_q.push_back(make_sprite(24'h001000, 24'h002000, 64, 32, 16'd16383,
                                   16'sd0, -16'sd128, 32'h00FF00FF));
    sprite_q.push_back(make_sprite(24'h001000, 24'h002000, 1024, 1, 16'd65535,
                                   16'sd1, 16'sd1, 32'hFF00FF00));
    sprite_q.push_back(make_sprite(24'hFFFFFF, 24'h000001, 1, 1024, 16'd1,
                                   -16'sd1, 16'h7FFF, 32'h80000001));
    sprite_q.push_back(make_sprite(24'h555555, 24'hAAAAAA, 1365, 682, 16'h5555,
                                   16'h5555, 16'hAAAA, 32'h55555555));
    sprite_q.push_back(make_sprite(24'hAAAAAA, 24'h555555, 682, 1365, 16'hAAAA,
                                   16'hAAAA, 16'h5555, 32'hAAAAAAAA));
    wait_idle();

    // Extreme camera settings, each followed by directed and random sprites.
    for (int ph = 0; ph < 4; ph++) begin
      random_camera(1'b1);
      if (ph == 0) begin
        write_reg(REG_CAMERA_ZOOM, 24'd0);
        write_reg(3'd6, 24'($urandom));   // unused index, must be ignored
        write_reg(3'd7, 24'($urandom));
      end
      commit_regs();
      sprite_q.push_back(make_sprite(24'h7FFFFF, 24'h800000, 1024, 1024, 16'd0,
                                     16'h7FFF, 16'h8000, $urandom));
      for (int n = 0; n < 60; n++) sprite_q.push_back(random_sprite());
      wait_idle();
    end

    // Random camera settings with random sprites; the last phase runs without idling.
    for (int ph = 0; ph < 7; ph++) begin
      random_camera(1'b0);
      commit_regs();
      if (ph == 6) calm = 1'b1;
      for (int n = 0; n < 213; n++) sprite_q.push_back(random_sprite());
      wait_idle();
    end

    $display("covered %0d sprites, %0d results and %0d register writes", sprites_sent,
             quads_seen, reg_writes);
    $display("camera phases: reset, 4 at range extremes, 7 random; %0d mismatches", mismatches);
    if (mismatches == 0 && corners_q.size() == 0) begin
      $display("sprite_quad_camera_transform test passed");
    end else begin
      $display("sprite_quad_camera_transform test failed");
    end
    $finish;
  end

endmodule
